/* sv/quadrature_prescaled_position_defines.svh */
// assertion macros shared by the quadrature position block
`ifndef QUADRATURE_PRESCALED_POSITION_DEFINES_SVH
`define QUADRATURE_PRESCALED_POSITION_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising clock edge
`define QPP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quadrature position check failed");
// next-cycle implication, checked on every rising clock edge
`define QPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quadrature position check failed");
`else
`define QPP_ASSERT_SAME(label, clk, rst, ante, cons)
`define QPP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/qpp_pkg.sv */
// types, constants and decode function for the quadrature position block
package qpp_pkg;

   // transitions that make up one position step
   localparam logic signed [4:0] TRANSITIONS_PER_STEP = 5'sd10;

   // result step event codes
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_FORWARD  = 2'd1;
   localparam logic [1:0] EV_BACKWARD = 2'd2;

   // request action codes
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_LOAD   = 1'b1;

   typedef enum logic [1:0] {
      TR_NONE,
      TR_FORWARD,
      TR_BACKWARD,
      TR_BAD
   } trans_type;

   // captured request beat handed to the tracking stage
   typedef struct packed {
      logic               valid;
      logic               action;
      logic               chan_a;
      logic               chan_b;
      logic signed [15:0] new_position;
   } stage_type;

   // code is {new b, new a, prev b, prev a}
   function automatic trans_type decode_transition(input logic [3:0] code);
      trans_type kind;
      unique case (code)
         4'd1, 4'd7, 4'd8, 4'd14:  kind = TR_FORWARD;
         4'd2, 4'd4, 4'd11, 4'd13: kind = TR_BACKWARD;
         4'd3, 4'd6, 4'd9, 4'd12:  kind = TR_BAD;
         default:                  kind = TR_NONE;
      endcase
      return kind;
   endfunction

endpackage

/* sv/qpp_if.sv */
// request and response channel interfaces
interface qpp_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic               chan_a;
   logic               chan_b;
   logic signed [15:0] new_position;

   modport source (output valid, action, chan_a, chan_b, new_position, input ready);
   modport sink   (input valid, action, chan_a, chan_b, new_position, output ready);
endinterface

interface qpp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] position;
   logic [1:0]         step_event;
   logic               bad_transition;

   modport source (output valid, position, step_event, bad_transition, input ready);
   modport sink   (input valid, position, step_event, bad_transition, output ready);
endinterface

/* sv/qpp_in_reg.sv */
// input register stage for request beats
module qpp_in_reg (
   input  logic              clock,
   input  logic              reset,
   qpp_req_if.sink           req_chan,
   input  logic              advance,
   output qpp_pkg::stage_type stage
);

   logic               valid_ff,    valid_in;
   logic               action_ff,   action_in;
   logic               chan_a_ff,   chan_a_in;
   logic               chan_b_ff,   chan_b_in;
   logic signed [15:0] new_pos_ff,  new_pos_in;
   logic               take;

   // stage frees up when empty or when its beat moves on, never in reset
   assign req_chan.ready = !reset && (!valid_ff || advance);
   assign take           = req_chan.valid && req_chan.ready;

   // next values of the stage
   always_comb begin
      valid_in   = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      action_in  = take ? req_chan.action       : action_ff;
      chan_a_in  = take ? req_chan.chan_a       : chan_a_ff;
      chan_b_in  = take ? req_chan.chan_b       : chan_b_ff;
      new_pos_in = take ? req_chan.new_position : new_pos_ff;
   end

   // control flop
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload flops
   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      chan_a_ff  <= chan_a_in;
      chan_b_ff  <= chan_b_in;
      new_pos_ff <= new_pos_in;
   end

   assign stage.valid        = valid_ff;
   assign stage.action       = action_ff;
   assign stage.chan_a       = chan_a_ff;
   assign stage.chan_b       = chan_b_ff;
   assign stage.new_position = new_pos_ff;

endmodule

/* sv/qpp_track.sv */
// decode, prescale and position tracking with the response register
module qpp_track (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [14:0]        csr_wdata,
   input  qpp_pkg::stage_type stage,
   output logic               advance,
   qpp_rsp_if.source          rsp_chan
);

   logic [14:0]        step_ff,    step_in;
   logic               prev_a_ff,  prev_a_in;
   logic               prev_b_ff,  prev_b_in;
   logic signed [4:0]  count_ff,   count_in;
   logic signed [15:0] pos_ff,     pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         event_ff,   event_in;
   logic               bad_ff,     bad_in;
   logic               changed;
   logic signed [4:0]  count_step;
   qpp_pkg::trans_type kind;

   // a beat moves on when the response slot is free or being drained
   assign advance = stage.valid && (!rsp_valid_ff || rsp_chan.ready);

   // transition decode
   assign changed = (stage.chan_a != prev_a_ff) || (stage.chan_b != prev_b_ff);
   assign kind    = qpp_pkg::decode_transition({stage.chan_b, stage.chan_a,
                                                prev_b_ff, prev_a_ff});

   // count after this transition, before the limit test
   always_comb begin
      unique case (kind)
         qpp_pkg::TR_FORWARD:  count_step = count_ff + 5'sd1;
         qpp_pkg::TR_BACKWARD: count_step = count_ff - 5'sd1;
         default:              count_step = count_ff;
      endcase
   end

   // next state and response
   always_comb begin
      step_in      = csr_we ? csr_wdata : step_ff;
      prev_a_in    = prev_a_ff;
      prev_b_in    = prev_b_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      event_in     = event_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (advance) begin
         rsp_valid_in = 1'b1;
         event_in     = qpp_pkg::EV_NONE;
         bad_in       = 1'b0;
         priority if (stage.action == qpp_pkg::ACT_LOAD) begin
            pos_in = stage.new_position;
         end else if (changed) begin
            prev_a_in = stage.chan_a;
            prev_b_in = stage.chan_b;
            bad_in    = (kind == qpp_pkg::TR_BAD);
            priority if (count_step >= qpp_pkg::TRANSITIONS_PER_STEP) begin
               count_in = '0;
               pos_in   = pos_ff + $signed({1'b0, step_ff});
               event_in = qpp_pkg::EV_FORWARD;
            end else if (count_step <= -qpp_pkg::TRANSITIONS_PER_STEP) begin
               count_in = '0;
               pos_in   = pos_ff - $signed({1'b0, step_ff});
               event_in = qpp_pkg::EV_BACKWARD;
            end else begin
               count_in = count_step;
            end
         end else begin
            pos_in = pos_ff;
         end
      end
   end

   // state and control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 15'd1;
         prev_a_ff    <= 1'b1;
         prev_b_ff    <= 1'b1;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         prev_a_ff    <= prev_a_in;
         prev_b_ff    <= prev_b_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload flops
   always_ff @(posedge clock) begin
      event_ff <= event_in;
      bad_ff   <= bad_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.position       = pos_ff;
   assign rsp_chan.step_event     = event_ff;
   assign rsp_chan.bad_transition = bad_ff;

endmodule

/* sv/quadrature_prescaled_position.sv */
// Quadrature position tracker with a transition prescaler, top level.
// Path: an accepted request beat passes the input register, then decode and
// update into the response register. Throughput: one beat per cycle while
// responses are taken; the update loop closes through its state registers.
// Reset: synchronous, active high; position 0, count 0, idle levels high,
// step per tick 1, both channels empty.
`include "quadrature_prescaled_position_defines.svh"

module quadrature_prescaled_position (
   input  logic        clock,
   input  logic        reset,
   qpp_req_if.sink     req_chan,
   qpp_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [14:0] csr_wdata
);

   qpp_pkg::stage_type stage;
   logic               advance;

   // input register
   qpp_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .stage    (stage)
   );

   // tracking stage and response register
   qpp_track u_track (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stage     (stage),
      .advance   (advance),
      .rsp_chan  (rsp_chan)
   );

   // a step and a double-channel jump never come together
   `QPP_ASSERT_SAME(a_step_not_bad, clock, reset,
      rsp_chan.valid && rsp_chan.bad_transition, rsp_chan.step_event == qpp_pkg::EV_NONE)

   // a load beat shows up next cycle with the loaded position and no event
   `QPP_ASSERT_NEXT(a_load_result, clock, reset,
      advance && stage.action == qpp_pkg::ACT_LOAD,
      rsp_chan.valid && rsp_chan.position == $past(stage.new_position)
         && rsp_chan.step_event == qpp_pkg::EV_NONE && !rsp_chan.bad_transition)

   // response register is empty right after reset
   `QPP_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_chan.valid)

endmodule
